FILE: rtl/core/cht_pkg.sv
// cht_pkg: shared types and constants of the chained hash table.
// No dependencies.
`default_nettype none
package cht_pkg;
  localparam int unsigned Buckets = 256;
  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned BktW = $clog2(Buckets);
  localparam int unsigned NodeW = $clog2(PoolNodes);
  localparam int unsigned LinkW = $clog2(PoolNodes + 1);
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 32;
  localparam int unsigned CfgW = 32;
  localparam int unsigned CntW = 9;
  localparam logic [LinkW-1:0] Nil = LinkW'(PoolNodes);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic {
    CFG_BUCKETS = 1'b0,
    CFG_MISS    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] found_value;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [BktW-1:0] bucket;
  } job_t;

  typedef enum logic [3:0] {
    FS_IDLE, FS_DIV, FS_OUT
  } fstate_e;

  typedef enum logic [3:0] {
    BS_INIT, BS_IDLE, BS_HEAD, BS_RDN, BS_CHK, BS_DECIDE,
    BS_UNL1, BS_UNL2, BS_INS1, BS_INS2, BS_RESP
  } bstate_e;
endpackage
`default_nettype wire

FILE: rtl/core/chained_hash_table.sv
// chained_hash_table: top level, front divider, queue and table engine.
// Depends on cht_pkg, cht_front, cht_queue, cht_back.
//
// Usage: requests enter through a queue-like port (push_i / full_o) as a
// req_t {func, key, value}; results leave through empty_o / pop_i as an
// rsp_t {status, found_value}, one result per request, in order.
// The front computes key mod bucket_count bit-serially, then hands the
// request through a two-entry queue to the back engine, which walks the
// chain: it reads the bucket head, then reads and checks each node in
// turn, decides, and for an insert or delete that writes takes a further
// write step before the result shows. The front takes the next request
// while the back works, once it has handed the last one to the queue;
// throughput is set by the slower of the two.
// After reset the back sweeps the node link and bucket memories;
// requests queue up meanwhile. A result waits in the output register
// until popped; the engine stalls, the queue fills, full_o rises.
// Config: cfg_we_i writes register cfg_idx_i (0 bucket_count, 1 miss).
`default_nettype none
module chained_hash_table import cht_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire req_t            req_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output rsp_t                 rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);
  logic [CntW-1:0] count_q;
  logic [ValW-1:0] miss_q;
  logic fv, fr, qv, qr, busy;
  job_t fj, qj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(Buckets);
      miss_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUCKETS: count_q <= cfg_wdata_i[CntW-1:0];
        CFG_MISS: miss_q <= cfg_wdata_i[ValW-1:0];
        default: ;
      endcase
    end
  end

  cht_front u_front (.clk_i, .rst_ni, .push_i, .full_o, .req_i,
    .count_i(count_q), .job_valid_o(fv), .job_ready_i(fr), .job_o(fj));
  cht_queue u_queue (.clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr),
    .in_i(fj), .out_valid_o(qv), .out_ready_i(qr), .out_o(qj));
  cht_back u_back (.clk_i, .rst_ni, .job_valid_i(qv), .job_ready_o(qr),
    .job_i(qj), .miss_i(miss_q), .empty_o, .pop_i, .rsp_o, .busy_o(busy));

  // A result is only presented when the engine is busy with it.
  a_resp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> busy) else $error("result shown while engine idle");
  // A result holds until it is popped.
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(rsp_o)))
    else $error("result dropped before pop");
  // A job the queue cannot take stays offered by the front while it waits.
  a_q_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv && !fr) |=> fv) else $error("front job lost");
endmodule
`default_nettype wire

FILE: rtl/core/cht_ram.sv
// cht_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/cht_front.sv
// cht_front: accepts requests, computes bucket = key mod count (restoring
// division, one bit per cycle). Depends on cht_pkg.
`default_nettype none
module cht_front import cht_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire req_t            req_i,
  input  wire logic [CntW-1:0] count_i,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i,
  output job_t                 job_o
);
  fstate_e state_q, state_d;
  req_t req_q;
  logic [CntW-1:0] div_q;
  logic [KeyW-1:0] sh_q;
  logic [CntW:0] rem_q, rem_d;
  logic [4:0] cnt_q;
  logic [CntW:0] trial;

  always_comb begin
    trial = {rem_q[CntW-1:0], sh_q[KeyW-1]};
    rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FS_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    full_o = 1'b1;
    job_valid_o = 1'b0;
    unique case (state_q)
      FS_IDLE: begin
        full_o = 1'b0;
        if (push_i) state_d = FS_DIV;
      end
      FS_DIV: if (cnt_q == 5'd0) state_d = FS_OUT;
      FS_OUT: begin
        job_valid_o = 1'b1;
        if (job_ready_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && push_i) begin
      req_q <= req_i;
      sh_q <= req_i.key;
      rem_q <= '0;
      cnt_q <= 5'(KeyW - 1);
      if (count_i == '0) div_q <= CntW'(1);
      else if (count_i > CntW'(Buckets)) div_q <= CntW'(Buckets);
      else div_q <= count_i;
    end else if (state_q == FS_DIV) begin
      rem_q <= rem_d;
      sh_q <= {sh_q[KeyW-2:0], 1'b0};
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_comb begin
    job_o.func = req_q.func;
    job_o.key = req_q.key;
    job_o.value = req_q.value;
    job_o.bucket = rem_q[BktW-1:0];
  end
endmodule
`default_nettype wire

FILE: rtl/core/cht_queue.sv
// cht_queue: two-entry queue between front and back.
// Depends on cht_pkg.
`default_nettype none
module cht_queue import cht_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire job_t in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_o
);
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i;
  end
endmodule
`default_nettype wire

FILE: rtl/core/cht_back.sv
// cht_back: table state machine over bucket and node memories.
// Depends on cht_pkg, cht_ram.
`default_nettype none
module cht_back import cht_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire job_t            job_i,
  input  wire logic [ValW-1:0] miss_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output rsp_t                 rsp_o,
  output logic                 busy_o
);
  bstate_e state_q, state_d;
  job_t job_q;
  logic [LinkW-1:0] cur_q, prev_q, hnext_q, free_q, init_q;
  logic [NodeW:0] steps_q;
  logic hit_q;
  rsp_t rsp_q;

  logic hb_we; logic [BktW-1:0] hb_a; logic [LinkW-1:0] hb_wd, hb_rd;
  logic nk_we; logic [NodeW-1:0] n_a; logic [KeyW-1:0] nk_rd;
  logic [ValW-1:0] nv_rd; logic nl_we; logic [LinkW-1:0] nl_wd, nl_rd;

  cht_ram #(.Width(LinkW), .Depth(Buckets)) u_head (
    .clk_i, .we_i(hb_we), .addr_i(hb_a), .wdata_i(hb_wd), .rdata_o(hb_rd));
  cht_ram #(.Width(KeyW), .Depth(PoolNodes)) u_key (
    .clk_i, .we_i(nk_we), .addr_i(n_a), .wdata_i(job_q.key), .rdata_o(nk_rd));
  cht_ram #(.Width(ValW), .Depth(PoolNodes)) u_val (
    .clk_i, .we_i(nk_we), .addr_i(n_a), .wdata_i(job_q.value), .rdata_o(nv_rd));
  cht_ram #(.Width(LinkW), .Depth(PoolNodes)) u_link (
    .clk_i, .we_i(nl_we), .addr_i(n_a), .wdata_i(nl_wd), .rdata_o(nl_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_INIT;
      init_q <= '0;
      free_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BS_INIT) init_q <= init_q + LinkW'(1);
      if (state_q == BS_INS1) free_q <= nl_rd;
      if (state_q == BS_UNL2) free_q <= cur_q;
    end
  end

  assign busy_o = state_q != BS_IDLE;
  assign empty_o = state_q != BS_RESP;
  assign rsp_o = rsp_q;
  assign job_ready_o = state_q == BS_IDLE;

  logic init_node, init_bkt;
  assign init_node = init_q < LinkW'(PoolNodes);
  assign init_bkt = init_q < LinkW'(Buckets);

  always_comb begin
    state_d = state_q;
    hb_we = 1'b0; hb_a = job_q.bucket; hb_wd = '0;
    nk_we = 1'b0; nl_we = 1'b0; n_a = cur_q[NodeW-1:0]; nl_wd = '0;
    unique case (state_q)
      BS_INIT: begin
        hb_we = init_bkt; hb_a = init_q[BktW-1:0]; hb_wd = Nil;
        nl_we = init_node; n_a = init_q[NodeW-1:0]; nl_wd = init_q + LinkW'(1);
        if (!init_node && !init_bkt) state_d = BS_IDLE;
      end
      BS_IDLE: begin
        // start the head read of the incoming job's bucket
        hb_a = job_i.bucket;
        if (job_valid_i) state_d = BS_HEAD;
      end
      BS_HEAD: state_d = BS_RDN; // head read in flight
      BS_RDN: state_d = BS_CHK;  // node read in flight (cur loaded)
      BS_CHK: begin
        if (cur_q == Nil || steps_q[NodeW] || hit_q) state_d = BS_DECIDE;
        else state_d = BS_RDN;
      end
      BS_DECIDE: begin
        state_d = BS_RESP;
        if (job_q.func == FN_INSERT && !hit_q && free_q != Nil) begin
          n_a = free_q[NodeW-1:0]; state_d = BS_INS1;
        end else if (job_q.func == FN_DELETE && hit_q) begin
          if (prev_q == Nil) begin
            hb_we = 1'b1; hb_wd = hnext_q;
          end else begin
            nl_we = 1'b1; n_a = prev_q[NodeW-1:0]; nl_wd = hnext_q;
          end
          state_d = BS_UNL2;
        end
      end
      BS_INS1: begin
        // nl_rd holds free node's link; write node and relink head
        n_a = free_q[NodeW-1:0];
        nk_we = 1'b1; nl_we = 1'b1; nl_wd = hb_rd;
        hb_we = 1'b1; hb_wd = free_q;
        state_d = BS_RESP;
      end
      BS_UNL2: begin
        nl_we = 1'b1; nl_wd = free_q;
        state_d = BS_RESP;
      end
      BS_RESP: if (pop_i) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: if (job_valid_i) begin
        job_q <= job_i;
        hit_q <= 1'b0;
        prev_q <= Nil;
        steps_q <= '0;
      end
      BS_HEAD: cur_q <= hb_rd;
      BS_RDN: ;
      BS_CHK: if (!(cur_q == Nil || steps_q[NodeW] || hit_q)) begin
        if (nk_rd == job_q.key) begin
          hit_q <= 1'b1; hnext_q <= nl_rd;
          rsp_q.found_value <= nv_rd;
        end else begin
          prev_q <= cur_q; cur_q <= nl_rd;
          steps_q <= steps_q + (NodeW+1)'(1);
        end
      end
      BS_DECIDE: begin
        rsp_q.status <= ST_DONE;
        unique case (job_q.func)
          FN_INSERT: begin
            rsp_q.found_value <= '0;
            if (hit_q) rsp_q.status <= ST_DUP;
            else if (free_q == Nil) rsp_q.status <= ST_FULL;
          end
          FN_DELETE: begin
            rsp_q.found_value <= '0;
            if (!hit_q) rsp_q.status <= ST_MISS;
          end
          FN_LOOKUP: if (!hit_q) begin
            rsp_q.status <= ST_MISS; rsp_q.found_value <= miss_i;
          end
          default: rsp_q.found_value <= '0;
        endcase
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
